FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`else

`define ASSERT_HOLDS(label, clk, rst_n, cond)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/mrlb_pkg.sv
package mrlb_pkg;

    localparam int DATA_W    = 8;
    localparam int MSG_SEL_W = 6;
    localparam int BYTE_SEL_W = 8;
    localparam int MSG_LEN_W = 8;
    localparam int MSG_CNT_W = 7;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [DATA_W-1:0]     data_byte;
        logic                  end_of_message;
        logic [MSG_SEL_W-1:0]  msg_select;
        logic [BYTE_SEL_W-1:0] byte_select;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]    read_byte;
        logic                 read_valid;
        logic [MSG_LEN_W-1:0] msg_length;
        logic [MSG_CNT_W-1:0] msg_count;
        logic                 evicted;
        logic                 last_byte;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_RDESC,
        ST_RBYTE
    } t_state;

endpackage

FILE: hdl/mrlb_stream_if.sv
interface mrlb_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/mrlb_ram.sv
module mrlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/message_ring_log_buffer.sv
// Log buffer: a byte ring holds message text and a descriptor ring holds the
// start and length of each committed message. An append beat stores one byte
// (bytes past the line limit are dropped) and its end flag commits the message;
// once the byte ring is full, new bytes overwrite the oldest and the oldest
// message they hit is evicted, as is the oldest descriptor when the descriptor
// ring is full. A read beat returns byte k of the j-th oldest message together
// with its length and the stored message count. Every request gives exactly one
// response. An append first reads the oldest entry from the descriptor ram,
// then applies the update; a read reads the descriptor ram, then the byte
// ram. One request is in flight at a time, and a new request is taken while
// the previous response still waits in the output register. No clearing pass
// runs after reset; the rams need no initial contents.
`include "assert_macros.svh"

module message_ring_log_buffer
    import mrlb_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096,
    parameter int MAX_MESSAGES = 64,
    parameter int LINE_BYTES   = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mrlb_stream_if.sink   i_req,
    mrlb_stream_if.source o_rsp
);
    localparam int AW     = $clog2(BUFFER_BYTES);
    localparam int DW     = $clog2(MAX_MESSAGES);
    localparam int CW     = $clog2(MAX_MESSAGES + 1);
    localparam int LW     = $clog2(LINE_BYTES);
    localparam int DESC_W = AW + LW;
    localparam int SW     = ((DW > MSG_SEL_W) ? DW : MSG_SEL_W) + 1;
    localparam logic [LW-1:0] LEN_MAX   = LW'(LINE_BYTES - 1);
    localparam logic [AW:0]   B_EXT     = (AW + 1)'(BUFFER_BYTES);
    localparam logic [SW-1:0] M_EXT     = SW'(MAX_MESSAGES);
    localparam logic [CW-1:0] M_CNT     = CW'(MAX_MESSAGES);

    function automatic logic [AW-1:0] inc_pos(input logic [AW-1:0] p);
        return (p == AW'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DW-1:0] inc_desc(input logic [DW-1:0] d);
        return (d == DW'(MAX_MESSAGES - 1)) ? '0 : d + 1'b1;
    endfunction

    function automatic logic [CW-1:0] count_of(input logic [DW-1:0] head,
                                               input logic [DW-1:0] tail,
                                               input logic          full);
        logic [CW-1:0] c;
        if (full) begin
            c = M_CNT;
        end else if (head >= tail) begin
            c = CW'(head) - CW'(tail);
        end else begin
            c = M_CNT - CW'(tail) + CW'(head);
        end
        return c;
    endfunction

    // control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_wpos, n_wpos;
    logic [AW-1:0]   r_opos, n_opos;
    logic            r_bfull, n_bfull;
    logic [DW-1:0]   r_head, n_head;
    logic [DW-1:0]   r_tail, n_tail;
    logic            r_dfull, n_dfull;
    logic [AW-1:0]   r_cur_start, n_cur_start;
    logic [LW-1:0]   r_cur_len, n_cur_len;
    logic            r_out_valid, n_out_valid;

    // payload
    t_req            r_req;
    t_rsp            r_out, n_out;
    logic            r_sel_ok, n_sel_ok;
    logic            r_hit, n_hit;
    logic            r_last, n_last;
    logic [LW-1:0]   r_sel_len, n_sel_len;

    // ram ports
    logic              desc_we, desc_re;
    logic [DW-1:0]     desc_waddr, desc_raddr;
    logic [DESC_W-1:0] desc_wdata, desc_rdata;
    logic              byte_we, byte_re;
    logic [AW-1:0]     byte_waddr, byte_raddr;
    logic [DATA_W-1:0] byte_wdata, byte_rdata;

    logic            w_acc;
    logic            w_out_free;
    logic [CW-1:0]   w_count;
    logic [SW-1:0]   w_idx_sum;
    logic [DW-1:0]   w_rd_idx;
    logic [AW-1:0]   w_d_start;
    logic [LW-1:0]   w_d_len;

    // append path
    logic            w_store;
    logic [AW-1:0]   w_off;
    logic            w_covers;
    logic            w_ev_byte, w_ev_desc;
    logic [DW-1:0]   w_tail1, w_tail2, w_head_n;
    logic            w_dfull1, w_dfull_n;
    logic [AW-1:0]   w_wpos_n, w_opos_n;
    logic [LW-1:0]   w_len1;
    logic            w_app_go;

    // read path
    logic [AW:0]     w_baddr_sum;

    assign w_acc      = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_count    = count_of(r_head, r_tail, r_dfull);
    assign w_d_start  = desc_rdata[DESC_W-1 -: AW];
    assign w_d_len    = desc_rdata[LW-1:0];

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // ring index of the selected message
    always_comb begin
        w_idx_sum = SW'(r_tail) + SW'(i_req.payload.msg_select);
        if (w_idx_sum >= M_EXT) begin
            w_idx_sum = w_idx_sum - M_EXT;
        end
        w_rd_idx = w_idx_sum[DW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = (i_req.payload.req_type == REQ_READ) ? ST_RDESC : ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDESC: begin
                n_state = ST_RBYTE;
            end
            ST_RBYTE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // append update, evaluated against the oldest descriptor read at accept
    always_comb begin
        w_store = (r_cur_len < LEN_MAX);
        if (r_wpos >= w_d_start) begin
            w_off = r_wpos - w_d_start;
        end else begin
            w_off = AW'({1'b0, r_wpos} + B_EXT - {1'b0, w_d_start});
        end
        w_covers  = (w_off < AW'(w_d_len));
        w_ev_byte = w_store && r_bfull && (w_count != '0) && w_covers;
        w_tail1   = w_ev_byte ? inc_desc(r_tail) : r_tail;
        w_dfull1  = w_ev_byte ? 1'b0 : r_dfull;
        w_opos_n  = (w_store && r_bfull) ? inc_pos(r_opos) : r_opos;
        w_wpos_n  = w_store ? inc_pos(r_wpos) : r_wpos;
        w_len1    = w_store ? r_cur_len + 1'b1 : r_cur_len;
        w_head_n  = r_head;
        w_tail2   = w_tail1;
        w_dfull_n = w_dfull1;
        w_ev_desc = 1'b0;
        if (r_req.end_of_message) begin
            // full descriptor ring drops its oldest entry first
            w_ev_desc = w_dfull1;
            w_tail2   = w_dfull1 ? inc_desc(w_tail1) : w_tail1;
            w_head_n  = inc_desc(r_head);
            w_dfull_n = (w_head_n == w_tail2);
        end
    end

    // read byte address wraps round the byte ring
    always_comb begin
        w_baddr_sum = {1'b0, w_d_start} + (AW + 1)'(r_req.byte_select);
        if (w_baddr_sum >= B_EXT) begin
            w_baddr_sum = w_baddr_sum - B_EXT;
        end
    end

    // outputs and datapath
    always_comb begin
        n_wpos      = r_wpos;
        n_opos      = r_opos;
        n_bfull     = r_bfull;
        n_head      = r_head;
        n_tail      = r_tail;
        n_dfull     = r_dfull;
        n_cur_start = r_cur_start;
        n_cur_len   = r_cur_len;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_sel_ok    = r_sel_ok;
        n_hit       = r_hit;
        n_last      = r_last;
        n_sel_len   = r_sel_len;
        w_app_go    = 1'b0;

        desc_re    = 1'b0;
        desc_raddr = r_tail;
        byte_re    = 1'b0;
        byte_raddr = w_baddr_sum[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                desc_re    = w_acc;
                desc_raddr = (i_req.payload.req_type == REQ_READ) ? w_rd_idx : r_tail;
            end
            ST_APPEND: begin
                if (w_out_free) begin
                    w_app_go    = 1'b1;
                    n_wpos      = w_wpos_n;
                    n_opos      = w_opos_n;
                    n_bfull     = r_bfull || (w_store && (w_wpos_n == w_opos_n));
                    n_head      = w_head_n;
                    n_tail      = w_tail2;
                    n_dfull     = w_dfull_n;
                    n_cur_start = r_req.end_of_message ? w_wpos_n : r_cur_start;
                    n_cur_len   = r_req.end_of_message ? '0 : w_len1;
                    n_out_valid = 1'b1;
                    n_out.read_byte  = '0;
                    n_out.read_valid = 1'b0;
                    n_out.msg_length = '0;
                    n_out.msg_count  = MSG_CNT_W'(count_of(w_head_n, w_tail2, w_dfull_n));
                    n_out.evicted    = w_ev_byte || w_ev_desc;
                    n_out.last_byte  = 1'b0;
                end
            end
            ST_RDESC: begin
                byte_re   = 1'b1;
                n_sel_ok  = (SW'(r_req.msg_select) < SW'(w_count));
                n_sel_len = w_d_len;
                n_hit     = n_sel_ok && ((BYTE_SEL_W + 1)'(r_req.byte_select)
                                         < (BYTE_SEL_W + 1)'(w_d_len));
                n_last    = (((BYTE_SEL_W + 1)'(r_req.byte_select) + 1'b1)
                             == (BYTE_SEL_W + 1)'(w_d_len));
            end
            ST_RBYTE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.read_byte  = r_hit ? byte_rdata : '0;
                    n_out.read_valid = r_hit;
                    n_out.msg_length = r_sel_ok ? MSG_LEN_W'(r_sel_len) : '0;
                    n_out.msg_count  = MSG_CNT_W'(w_count);
                    n_out.evicted    = 1'b0;
                    n_out.last_byte  = r_hit && r_last;
                end
            end
            default: begin
            end
        endcase

        desc_we    = w_app_go && r_req.end_of_message;
        desc_waddr = r_head;
        desc_wdata = {r_cur_start, w_len1};
        byte_we    = w_app_go && w_store;
        byte_waddr = r_wpos;
        byte_wdata = r_req.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wpos      <= '0;
            r_opos      <= '0;
            r_bfull     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_dfull     <= 1'b0;
            r_cur_start <= '0;
            r_cur_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wpos      <= n_wpos;
            r_opos      <= n_opos;
            r_bfull     <= n_bfull;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_dfull     <= n_dfull;
            r_cur_start <= n_cur_start;
            r_cur_len   <= n_cur_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= i_req.payload;
        end
        r_out     <= n_out;
        r_sel_ok  <= n_sel_ok;
        r_hit     <= n_hit;
        r_last    <= n_last;
        r_sel_len <= n_sel_len;
    end

    mrlb_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_MESSAGES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wdata (desc_wdata),
        .i_re    (desc_re),
        .i_raddr (desc_raddr),
        .o_rdata (desc_rdata)
    );

    mrlb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_BYTES)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    // a full descriptor ring has met its own tail
    `ASSERT_HOLDS(a_desc_full_ptrs, i_clk, i_rst_n, !r_dfull || (r_head == r_tail))
    // once the byte ring is full the oldest byte sits at the write pointer
    `ASSERT_HOLDS(a_byte_full_ptrs, i_clk, i_rst_n, !r_bfull || (r_wpos == r_opos))
    // a valid read never reports an eviction and names a non-empty message
    `ASSERT_IMPL(a_read_shape, i_clk, i_rst_n, r_out_valid && r_out.read_valid, !r_out.evicted && (r_out.msg_length != '0))

endmodule
